// File: sv/coet_pkg.sv
// shared types, constants and saturation helpers for the critical orbit escape time block
// no dependencies; imported by critical_orbit_escape_time and its testbench
`default_nettype none

package coet_pkg;

    localparam int FRAC_BITS   = 28;
    localparam int VAL_W       = 32;
    localparam int MAX_DEGREE  = 8;
    localparam int DEG_W       = 4;
    localparam int ITER_W      = 12;
    localparam int COLOR_W     = 13;
    localparam int PROD_W      = 2 * VAL_W;
    localparam int ACC_W       = PROD_W + 2;
    localparam int DVD_W       = PROD_W + FRAC_BITS;
    localparam int DCNT_W      = $clog2(DVD_W);
    localparam int ESC_RADIUS2 = 100;
    localparam int PH_W        = 3;

    localparam logic [PH_W-1:0]         PH_LAST   = PH_W'(5);
    localparam logic signed [ACC_W-1:0] ESC_LIMIT = ACC_W'(ESC_RADIUS2) <<< FRAC_BITS;
    localparam logic signed [ACC_W-1:0] SAT_MAX   = ACC_W'(64'sh7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] SAT_MIN   = -ACC_W'(64'sh8000_0000);

    typedef enum logic [1:0] {
        REG_LAMBDA_RE,
        REG_LAMBDA_IM,
        REG_DEGREE,
        REG_MAX_ITER
    } cfg_idx_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] re;
        logic signed [VAL_W-1:0] im;
    } cplx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_NEG,
        ST_T,
        ST_W,
        ST_DEN,
        ST_LAM,
        ST_DIV,
        ST_DSC,
        ST_C1,
        ST_C2,
        ST_ORB_INIT,
        ST_NORM,
        ST_U,
        ST_PU,
        ST_V,
        ST_PV,
        ST_ORB_END,
        ST_FIN
    } state_t;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > SAT_MAX)
            r = SAT_MAX[VAL_W-1:0];
        else if (v < SAT_MIN)
            r = SAT_MIN[VAL_W-1:0];
        else
            r = v[VAL_W-1:0];
        return r;
    endfunction

    function automatic logic ovf32(input logic signed [ACC_W-1:0] v);
        return (v > SAT_MAX) || (v < SAT_MIN);
    endfunction

endpackage

`default_nettype wire

// File: sv/critical_orbit_escape_time.sv
// critical orbit escape time: setup with complex division, then two critical orbits
// one shared 32x32 multiplier and a bit-serial divider under a sequencer; uses coet_pkg
`default_nettype none
// setup includes two passes of the restoring divider, then the orbit steps and a final norm test, two orbits
// throughput: one transaction at a time; every complex multiply is 4 passes through the
//   single shared multiplier, which sets the step time
// reset: asynchronous active low; registers return to lambda 1.0, degree 3, 100 iterations

module critical_orbit_escape_time (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output      logic                           in_ready,
    input  wire logic signed [31:0]             point_re,
    input  wire logic signed [31:0]             point_im,
    output      logic                           out_valid,
    input  wire logic                           out_ready,
    output      logic                           trapped,
    output      logic [12:0]                    color_index,
    output      logic                           degenerate,
    input  wire logic                           cfg_we,
    input  wire coet_pkg::cfg_idx_t             cfg_addr,
    input  wire logic [31:0]                    cfg_wdata
);
    import coet_pkg::*;

    state_t state_reg, state_next;
    logic [PH_W-1:0] ph_reg, ph_next;
    logic out_valid_reg, out_valid_next;

    logic signed [VAL_W-1:0] lam_re_reg, lam_im_reg;
    logic [DEG_W-1:0] degree_reg;
    logic [ITER_W-1:0] max_it_reg;

    cplx_t a_reg, a_next, na_reg, na_next, t_reg, t_next, w_reg, w_next;
    cplx_t b_reg, b_next, d_reg, d_next, c_reg, c_next, z_reg, z_next;
    cplx_t u_reg, u_next, p_reg, p_next, v_reg, v_next;
    logic [DEG_W-1:0] deg_reg, deg_next, cnt_reg, cnt_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_re_reg, acc_re_next, acc_im_reg, acc_im_next;
    logic signed [ACC_W-1:0] num_re_reg, num_re_next, num_im_reg, num_im_next;
    logic [PROD_W-1:0] den_reg, den_next, rem_reg, rem_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [VAL_W:0] q_reg, q_next;
    logic big_reg, big_next, div_sel_reg, div_sel_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic orb_sel_reg, orb_sel_next, ovf_reg, ovf_next, degen_reg, degen_next;
    logic [ITER_W-1:0] n_reg, n_next, na_cnt_reg, na_cnt_next;
    logic signed [VAL_W-1:0] za_im_reg, za_im_next;
    logic trapped_reg, trapped_next, degen_out_reg, degen_out_next;
    logic [COLOR_W-1:0] color_reg, color_next;

    // shared multiplier and accumulator
    cplx_t opx, opy, lam, res;
    logic signed [VAL_W-1:0] mul_a, mul_b;
    logic signed [ACC_W-1:0] term;
    logic mul_state, use_shift, re_sub, im_sub, done, res_ovf;
    logic [5:0] k_w;

    // divider step
    logic [PROD_W:0] rem_s;
    logic div_ge, div_last, div_neg;
    logic [VAL_W:0] q_step;
    logic big_step;
    logic signed [VAL_W-1:0] div_res;

    // orbit helpers
    logic signed [ACC_W-1:0] zc_re, zc_im;
    logic zc_ovf, escaped, fin_fire, trap_cond;
    logic [ITER_W-1:0] n_sel;
    logic signed [VAL_W-1:0] im_sel;

    assign lam = '{re: lam_re_reg, im: lam_im_reg};
    assign k_w = 6'(deg_reg) * 6'(deg_reg - DEG_W'(1));

    always_comb
    begin
        mul_state = 1'b1;
        use_shift = 1'b0;
        re_sub    = 1'b1;
        im_sub    = 1'b0;
        opx       = '0;
        opy       = '0;
        case (state_reg)
            ST_T, ST_C1:
            begin
                opx = t_reg; opy = na_reg; use_shift = 1'b1;
            end
            ST_W:
            begin
                opx = t_reg; opy = '{re: VAL_W'(k_w), im: '0};
            end
            ST_DEN:
            begin
                opx = w_reg; opy = w_reg; re_sub = 1'b0;
            end
            ST_LAM:
            begin
                opx = lam; opy = w_reg; re_sub = 1'b0; im_sub = 1'b1;
            end
            ST_DSC:
            begin
                opx = b_reg; opy = '{re: VAL_W'(deg_reg), im: '0};
            end
            ST_C2:
            begin
                opx = p_reg; opy = d_reg; use_shift = 1'b1;
            end
            ST_NORM:
            begin
                opx = z_reg; opy = z_reg; use_shift = 1'b1; re_sub = 1'b0;
            end
            ST_PU:
            begin
                opx = p_reg; opy = u_reg; use_shift = 1'b1;
            end
            ST_V:
            begin
                opx = z_reg; opy = '{re: VAL_W'(deg_reg - DEG_W'(1)), im: '0};
            end
            ST_PV:
            begin
                opx = p_reg; opy = v_reg; use_shift = 1'b1;
            end
            default:
            begin
                mul_state = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (ph_reg[1:0])
            2'd0:    begin mul_a = opx.re; mul_b = opy.re; end
            2'd1:    begin mul_a = opx.im; mul_b = opy.im; end
            2'd2:    begin mul_a = opx.re; mul_b = opy.im; end
            default: begin mul_a = opx.im; mul_b = opy.re; end
        endcase
    end

    assign term = use_shift ? ACC_W'(prod_reg >>> FRAC_BITS) : ACC_W'(prod_reg);
    assign done = mul_state && (ph_reg == PH_LAST);
    assign res  = '{re: sat32(acc_re_reg), im: sat32(acc_im_reg)};
    assign res_ovf = ovf32(acc_re_reg) | ovf32(acc_im_reg);
    assign escaped = acc_re_reg >= ESC_LIMIT;

    always_comb
    begin
        acc_re_next = acc_re_reg;
        acc_im_next = acc_im_reg;
        ph_next     = '0;
        if (mul_state)
        begin
            ph_next = (ph_reg == PH_LAST) ? '0 : ph_reg + PH_W'(1);
            case (ph_reg)
                PH_W'(1): acc_re_next = term;
                PH_W'(2): acc_re_next = re_sub ? acc_re_reg - term : acc_re_reg + term;
                PH_W'(3): acc_im_next = term;
                PH_W'(4): acc_im_next = im_sub ? acc_im_reg - term : acc_im_reg + term;
                default:  acc_re_next = acc_re_reg;
            endcase
        end
    end

    // restoring division, one quotient bit per cycle
    assign rem_s    = {rem_reg, dvd_reg[DVD_W-1]};
    assign div_ge   = rem_s >= {1'b0, den_reg};
    assign q_step   = {q_reg[VAL_W-1:0], div_ge};
    assign big_step = big_reg | q_reg[VAL_W];
    assign div_last = dcnt_reg == DCNT_W'(DVD_W - 1);
    assign div_neg  = div_sel_reg ? (num_im_reg < 0) : (num_re_reg > 0);

    always_comb
    begin
        if (div_neg)
        begin
            if (big_step || q_step > {1'b0, 1'b1, {(VAL_W-1){1'b0}}})
                div_res = SAT_MIN[VAL_W-1:0];
            else
                div_res = -q_step[VAL_W-1:0];
        end
        else
        begin
            if (big_step || q_step[VAL_W:VAL_W-1] != 2'b00)
                div_res = SAT_MAX[VAL_W-1:0];
            else
                div_res = q_step[VAL_W-1:0];
        end
    end

    assign zc_re  = ACC_W'(res.re) + ACC_W'(c_reg.re);
    assign zc_im  = ACC_W'(res.im) + ACC_W'(c_reg.im);
    assign zc_ovf = ovf32(zc_re) | ovf32(zc_im);

    assign fin_fire  = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);
    assign trap_cond = (na_cnt_reg >= max_it_reg) && (n_reg >= max_it_reg);
    assign n_sel     = (na_cnt_reg > n_reg) ? n_reg : na_cnt_reg;
    assign im_sel    = (na_cnt_reg > n_reg) ? z_reg.im : za_im_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_NEG;
            ST_NEG:      state_next = (deg_reg == DEG_W'(3)) ? ST_W : ST_T;
            ST_T:        if (done && (cnt_reg + DEG_W'(1) >= deg_reg)) state_next = ST_W;
            ST_W:        if (done) state_next = ST_DEN;
            ST_DEN:      if (done) state_next = (acc_re_reg == '0) ? ST_FIN : ST_LAM;
            ST_LAM:      if (done) state_next = ST_DIV;
            ST_DIV:      if (div_last && div_sel_reg) state_next = ST_DSC;
            ST_DSC:      if (done) state_next = ST_C1;
            ST_C1:       if (done) state_next = ST_C2;
            ST_C2:       if (done) state_next = ST_ORB_INIT;
            ST_ORB_INIT: state_next = ST_NORM;
            ST_NORM:
                if (done) state_next = ((n_reg >= max_it_reg) || escaped) ? ST_ORB_END : ST_U;
            ST_U:        state_next = ST_PU;
            ST_PU:       if (done && (cnt_reg + DEG_W'(1) >= deg_reg)) state_next = ST_V;
            ST_V:        if (done) state_next = ST_PV;
            ST_PV:
                if (done) state_next = (ovf_reg | res_ovf | zc_ovf) ? ST_ORB_END : ST_NORM;
            ST_ORB_END:  state_next = orb_sel_reg ? ST_FIN : ST_ORB_INIT;
            ST_FIN:      if (fin_fire) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        a_next = a_reg; na_next = na_reg; t_next = t_reg; w_next = w_reg;
        b_next = b_reg; d_next = d_reg; c_next = c_reg; z_next = z_reg;
        u_next = u_reg; p_next = p_reg; v_next = v_reg;
        deg_next = deg_reg; cnt_next = cnt_reg;
        num_re_next = num_re_reg; num_im_next = num_im_reg; den_next = den_reg;
        rem_next = rem_reg; dvd_next = dvd_reg; q_next = q_reg; big_next = big_reg;
        dcnt_next = dcnt_reg; div_sel_next = div_sel_reg;
        orb_sel_next = orb_sel_reg; ovf_next = ovf_reg; degen_next = degen_reg;
        n_next = n_reg; na_cnt_next = na_cnt_reg; za_im_next = za_im_reg;
        trapped_next = trapped_reg; color_next = color_reg; degen_out_next = degen_out_reg;
        case (state_reg)
            ST_IDLE:
            begin
                a_next = '{re: point_re, im: point_im};
                if (degree_reg < DEG_W'(3))
                    deg_next = DEG_W'(3);
                else if (degree_reg > DEG_W'(MAX_DEGREE))
                    deg_next = DEG_W'(MAX_DEGREE);
                else
                    deg_next = degree_reg;
                degen_next = 1'b0;
            end
            ST_NEG:
            begin
                na_next = '{re: sat32(-ACC_W'(a_reg.re)), im: sat32(-ACC_W'(a_reg.im))};
                t_next  = na_next;
                cnt_next = DEG_W'(3);
            end
            ST_T:
                if (done)
                begin
                    t_next = res;
                    cnt_next = cnt_reg + DEG_W'(1);
                end
            ST_W:
                if (done) w_next = res;
            ST_DEN:
                if (done)
                begin
                    den_next = acc_re_reg[PROD_W-1:0];
                    degen_next = acc_re_reg == '0;
                end
            ST_LAM:
                if (done)
                begin
                    num_re_next = acc_re_reg;
                    num_im_next = acc_im_reg;
                    dvd_next = {(acc_re_reg < 0 ? PROD_W'(-acc_re_reg) : PROD_W'(acc_re_reg)),
                                {FRAC_BITS{1'b0}}};
                    rem_next = '0; q_next = '0; big_next = 1'b0;
                    dcnt_next = '0; div_sel_next = 1'b0;
                end
            ST_DIV:
            begin
                rem_next  = div_ge ? PROD_W'(rem_s - {1'b0, den_reg}) : PROD_W'(rem_s);
                q_next    = q_step;
                big_next  = big_step;
                dvd_next  = dvd_reg << 1;
                dcnt_next = dcnt_reg + DCNT_W'(1);
                if (div_last)
                begin
                    if (!div_sel_reg)
                    begin
                        b_next.re = div_res;
                        dvd_next = {(num_im_reg < 0 ? PROD_W'(-num_im_reg)
                                                    : PROD_W'(num_im_reg)),
                                    {FRAC_BITS{1'b0}}};
                        rem_next = '0; q_next = '0; big_next = 1'b0;
                        dcnt_next = '0; div_sel_next = 1'b1;
                    end
                    else
                        b_next.im = div_res;
                end
            end
            ST_DSC:
                if (done)
                begin
                    d_next.re = sat32(ACC_W'(res.re) - ACC_W'(a_reg.re));
                    d_next.im = sat32(ACC_W'(res.im) - ACC_W'(a_reg.im));
                end
            ST_C1:
                if (done) p_next = res;
            ST_C2:
                if (done)
                begin
                    c_next = res;
                    orb_sel_next = 1'b0;
                end
            ST_ORB_INIT:
            begin
                z_next = orb_sel_reg ? b_reg : a_reg;
                n_next = '0;
                ovf_next = 1'b0;
            end
            ST_U:
            begin
                u_next.re = sat32(ACC_W'(z_reg.re) - ACC_W'(a_reg.re));
                u_next.im = sat32(ACC_W'(z_reg.im) - ACC_W'(a_reg.im));
                ovf_next = ovf_reg | ovf32(ACC_W'(z_reg.re) - ACC_W'(a_reg.re))
                                   | ovf32(ACC_W'(z_reg.im) - ACC_W'(a_reg.im));
                p_next = u_next;
                cnt_next = DEG_W'(2);
            end
            ST_PU:
                if (done)
                begin
                    p_next = res;
                    ovf_next = ovf_reg | res_ovf;
                    cnt_next = cnt_reg + DEG_W'(1);
                end
            ST_V:
                if (done)
                begin
                    v_next.re = sat32(ACC_W'(res.re) - ACC_W'(d_reg.re));
                    v_next.im = sat32(ACC_W'(res.im) - ACC_W'(d_reg.im));
                    ovf_next = ovf_reg | res_ovf
                             | ovf32(ACC_W'(res.re) - ACC_W'(d_reg.re))
                             | ovf32(ACC_W'(res.im) - ACC_W'(d_reg.im));
                end
            ST_PV:
                if (done)
                begin
                    z_next = '{re: sat32(zc_re), im: sat32(zc_im)};
                    ovf_next = ovf_reg | res_ovf | zc_ovf;
                    n_next = n_reg + ITER_W'(1);
                end
            ST_ORB_END:
                if (!orb_sel_reg)
                begin
                    na_cnt_next = n_reg;
                    za_im_next = z_reg.im;
                    orb_sel_next = 1'b1;
                end
            ST_FIN:
                if (fin_fire)
                begin
                    degen_out_next = degen_reg;
                    if (degen_reg)
                    begin
                        trapped_next = 1'b0;
                        color_next = '0;
                    end
                    else if (trap_cond)
                    begin
                        trapped_next = 1'b1;
                        color_next = '0;
                    end
                    else
                    begin
                        trapped_next = 1'b0;
                        color_next = {n_sel, im_sel <= 0};
                    end
                end
            default:
                a_next = a_reg;
        endcase
    end

    assign out_valid_next = (out_valid_reg && !out_ready) || fin_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ph_reg        <= '0;
            out_valid_reg <= 1'b0;
            lam_re_reg    <= 32'sh1000_0000;
            lam_im_reg    <= '0;
            degree_reg    <= DEG_W'(3);
            max_it_reg    <= ITER_W'(100);
        end
        else
        begin
            state_reg     <= state_next;
            ph_reg        <= ph_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_LAMBDA_RE: lam_re_reg <= cfg_wdata;
                    REG_LAMBDA_IM: lam_im_reg <= cfg_wdata;
                    REG_DEGREE:    degree_reg <= cfg_wdata[DEG_W-1:0];
                    REG_MAX_ITER:  max_it_reg <= cfg_wdata[ITER_W-1:0];
                    default:       lam_re_reg <= lam_re_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        acc_re_reg <= acc_re_next; acc_im_reg <= acc_im_next;
        a_reg <= a_next; na_reg <= na_next; t_reg <= t_next; w_reg <= w_next;
        b_reg <= b_next; d_reg <= d_next; c_reg <= c_next; z_reg <= z_next;
        u_reg <= u_next; p_reg <= p_next; v_reg <= v_next;
        deg_reg <= deg_next; cnt_reg <= cnt_next;
        num_re_reg <= num_re_next; num_im_reg <= num_im_next; den_reg <= den_next;
        rem_reg <= rem_next; dvd_reg <= dvd_next; q_reg <= q_next; big_reg <= big_next;
        dcnt_reg <= dcnt_next; div_sel_reg <= div_sel_next;
        orb_sel_reg <= orb_sel_next; ovf_reg <= ovf_next; degen_reg <= degen_next;
        n_reg <= n_next; na_cnt_reg <= na_cnt_next; za_im_reg <= za_im_next;
        trapped_reg <= trapped_next; color_reg <= color_next; degen_out_reg <= degen_out_next;
    end

    assign in_ready    = state_reg == ST_IDLE;
    assign out_valid   = out_valid_reg;
    assign trapped     = trapped_reg;
    assign color_index = color_reg;
    assign degenerate  = degen_out_reg;

`ifndef NO_ASSERTIONS
    a_ph_range: assert property (@(posedge clk) disable iff (!rst_n)
        ph_reg <= PH_LAST)
        else $error("multiply phase out of range");

    a_degen_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> !trapped && color_index == '0)
        else $error("degenerate result carries orbit data");

    a_trap_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && trapped |-> color_index == '0)
        else $error("trapped result has nonzero color");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_U |-> n_reg < max_it_reg)
        else $error("orbit step taken past the iteration limit");
`endif

endmodule

`default_nettype wire

// File: sim/tb_critical_orbit_escape_time.sv
// self-checking testbench for critical_orbit_escape_time: directed table, then random points
// under several register settings; depends on coet_pkg and critical_orbit_escape_time
`default_nettype none

module tb_critical_orbit_escape_time;
    import coet_pkg::*;

    typedef struct {
        logic        trapped;
        logic [12:0] color;
        logic        degen;
    } pixel_t;

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
        bit                 typed;
        pixel_t             px;
    } row_t;

    typedef struct {
        logic signed [31:0] lre;
        logic signed [31:0] lim;
        logic [3:0]         deg;
        logic [11:0]        iters;
        int                 count;
    } setting_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] point_re;
    logic signed [31:0] point_im;
    logic               out_valid;
    logic               out_ready;
    logic               trapped;
    logic [12:0]        color_index;
    logic               degenerate;
    logic               cfg_we;
    cfg_idx_t           cfg_addr;
    logic [31:0]        cfg_wdata;

    // predictor copy of the registers
    int          m_lre;
    int          m_lim;
    logic [3:0]  m_deg;
    logic [11:0] m_iters;

    pixel_t pixel_q[$];
    int     errors;
    bit     quiet;

    critical_orbit_escape_time dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .point_re    (point_re),
        .point_im    (point_im),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .trapped     (trapped),
        .color_index (color_index),
        .degenerate  (degenerate),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ---------------- fixed point predictor ----------------

    function automatic int sat(input longint v, inout bit ovf);
        if (v > 64'sd2147483647)
        begin
            ovf = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648)
        begin
            ovf = 1'b1;
            return 32'sh8000_0000;
        end
        return int'(v);
    endfunction

    // product rounded toward minus infinity
    function automatic longint qmul(input int x, input int y);
        return (longint'(x) * longint'(y)) >>> FRAC_BITS;
    endfunction

    task automatic cmul(input int xr, input int xi, input int yr, input int yi,
                        output int rr, output int ri, inout bit ovf);
        rr = sat(qmul(xr, yr) - qmul(xi, yi), ovf);
        ri = sat(qmul(xr, yi) + qmul(xi, yr), ovf);
    endtask

    function automatic bit escaped(input int zr, input int zi);
        logic [63:0] sr;
        logic [63:0] si;
        sr = 64'(longint'(zr) * longint'(zr)) >> FRAC_BITS;
        si = 64'(longint'(zi) * longint'(zi)) >> FRAC_BITS;
        return (sr + si) >= (64'd100 << FRAC_BITS);
    endfunction

    // magnitude of x + y, returns the sign
    function automatic bit sum_mag(input longint x, input longint y, output logic [63:0] m);
        logic [63:0] ux;
        logic [63:0] uy;
        ux = x < 0 ? 64'(-x) : 64'(x);
        uy = y < 0 ? 64'(-y) : 64'(y);
        if ((x < 0) == (y < 0))
        begin
            m = ux + uy;
            return x < 0;
        end
        if (ux >= uy)
        begin
            m = ux - uy;
            return x < 0;
        end
        m = uy - ux;
        return y < 0;
    endfunction

    function automatic int div_frac(input logic [63:0] m, input bit neg, input logic [63:0] den);
        logic [127:0] q;
        q = ({64'd0, m} << FRAC_BITS) / {64'd0, den};
        if (neg)
        begin
            if (q > 128'h8000_0000)
                return 32'sh8000_0000;
            return int'(-longint'(q[63:0]));
        end
        if (q > 128'h7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        return int'(q[31:0]);
    endfunction

    task automatic orbit_steps(input int zr0, input int zi0, input int ar, input int ai,
                               input int dr, input int di, input int cr, input int ci,
                               input int deg, input int lim, output int n, output int zi_last);
        int  zr;
        int  zi;
        int  ur;
        int  ui;
        int  pr;
        int  pi;
        int  vr;
        int  vi;
        bit  ovf;
        zr  = zr0;
        zi  = zi0;
        n   = 0;
        ovf = 1'b0;
        while (n < lim && !ovf && !escaped(zr, zi))
        begin
            ur = sat(longint'(zr) - ar, ovf);
            ui = sat(longint'(zi) - ai, ovf);
            pr = ur;
            pi = ui;
            for (int k = 2; k < deg; k++)
                cmul(pr, pi, ur, ui, pr, pi, ovf);
            vr = sat(longint'(sat(longint'(deg - 1) * zr, ovf)) - dr, ovf);
            vi = sat(longint'(sat(longint'(deg - 1) * zi, ovf)) - di, ovf);
            cmul(pr, pi, vr, vi, pr, pi, ovf);
            zr = sat(longint'(pr) + cr, ovf);
            zi = sat(longint'(pi) + ci, ovf);
            n++;
        end
        zi_last = zi;
    endtask

    task automatic predict_pixel(input int ar, input int ai, output pixel_t px);
        int          deg;
        int          nr;
        int          ni;
        int          tr;
        int          ti;
        int          wr;
        int          wi;
        int          br;
        int          bi;
        int          dr;
        int          di;
        int          cr;
        int          ci;
        int          n_a;
        int          n_b;
        int          zi_a;
        int          zi_b;
        int          n;
        int          zi;
        bit          ovf;
        bit          neg;
        logic [63:0] den;
        logic [63:0] m;
        deg = m_deg < 3 ? 3 : (m_deg > MAX_DEGREE ? MAX_DEGREE : int'(m_deg));
        ovf = 1'b0;
        nr  = sat(-longint'(ar), ovf);
        ni  = sat(-longint'(ai), ovf);
        tr  = nr;
        ti  = ni;
        for (int k = 3; k < deg; k++)
            cmul(tr, ti, nr, ni, tr, ti, ovf);
        wr  = sat(longint'(deg * (deg - 1)) * tr, ovf);
        wi  = sat(longint'(deg * (deg - 1)) * ti, ovf);
        den = 64'(longint'(wr) * wr) + 64'(longint'(wi) * wi);
        px.trapped = 1'b0;
        px.color   = '0;
        px.degen   = 1'b0;
        if (den == 0)
        begin
            px.degen = 1'b1;
            return;
        end
        neg = !sum_mag(longint'(m_lre) * wr, longint'(m_lim) * wi, m);
        br  = div_frac(m, neg, den);
        neg = sum_mag(longint'(m_lre) * wi, -(longint'(m_lim) * wr), m);
        bi  = div_frac(m, neg, den);
        dr  = sat(longint'(sat(longint'(deg) * br, ovf)) - ar, ovf);
        di  = sat(longint'(sat(longint'(deg) * bi, ovf)) - ai, ovf);
        cmul(tr, ti, nr, ni, cr, ci, ovf);
        cmul(cr, ci, dr, di, cr, ci, ovf);
        orbit_steps(ar, ai, ar, ai, dr, di, cr, ci, deg, int'(m_iters), n_a, zi_a);
        orbit_steps(br, bi, ar, ai, dr, di, cr, ci, deg, int'(m_iters), n_b, zi_b);
        if (n_a >= m_iters && n_b >= m_iters)
        begin
            px.trapped = 1'b1;
            return;
        end
        n  = n_a;
        zi = zi_a;
        if (n_a > n_b)
        begin
            n  = n_b;
            zi = zi_b;
        end
        px.color = 13'(2 * n + (zi > 0 ? 0 : 1));
    endtask

    // ---------------- checking ----------------

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pixel_q.size() == 0)
                flag_mismatch("unexpected transaction", 1, 0);
            else
            begin
                pixel_t e;
                e = pixel_q.pop_front();
                if (trapped !== e.trapped)
                    flag_mismatch("trapped", trapped, e.trapped);
                if (color_index !== e.color)
                    flag_mismatch("color_index", color_index, e.color);
                if (degenerate !== e.degen)
                    flag_mismatch("degenerate", degenerate, e.degen);
            end
        end
    end

    // result side stalls
    always @(posedge clk)
        out_ready <= quiet || ($urandom_range(99) >= 17);

    // ---------------- stimulus ----------------

    task automatic send_point(input int re, input int im, input bit typed, input pixel_t px);
        pixel_t e;
        while (!quiet && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        point_re <= re;
        point_im <= im;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (typed)
            e = px;
        else
            predict_pixel(re, im, e);
        pixel_q.push_back(e);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] mask,
                             input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= ($urandom() & ~mask) | (value & mask);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic apply_setting(input setting_t s);
        in_valid <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        write_reg(REG_LAMBDA_RE, 32'hFFFF_FFFF, s.lre);
        write_reg(REG_LAMBDA_IM, 32'hFFFF_FFFF, s.lim);
        write_reg(REG_DEGREE, 32'h0000_000F, 32'(s.deg));
        write_reg(REG_MAX_ITER, 32'h0000_0FFF, 32'(s.iters));
        m_lre   = s.lre;
        m_lim   = s.lim;
        m_deg   = s.deg;
        m_iters = s.iters;
        @(posedge clk);
    endtask

    function automatic int rand_point(input bit near);
        if (near)
            return int'($urandom_range(32'h5000_0000)) - 32'sh2800_0000;
        return int'($urandom());
    endfunction

    row_t     rows[$];
    setting_t plan[$];

    initial
    begin
        pixel_t none;
        pixel_t px;
        errors    = 0;
        quiet     = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        point_re  = '0;
        point_im  = '0;
        out_ready = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = REG_LAMBDA_RE;
        cfg_wdata = '0;
        m_lre     = 32'sh1000_0000;
        m_lim     = 0;
        m_deg     = 4'd3;
        m_iters   = 12'd100;
        none      = '{1'b0, 13'd0, 1'b0};

        // zero point: divisor vanishes
        rows.push_back('{32'sh0, 32'sh0, 1'b1, '{1'b0, 13'd0, 1'b1}});
        // far points escape before the first step from a
        rows.push_back('{32'sh8000_0000, 32'sh8000_0000, 1'b1, '{1'b0, 13'd1, 1'b0}});
        rows.push_back('{32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, '{1'b0, 13'd0, 1'b0}});
        rows.push_back('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, '{1'b0, 13'd0, 1'b0}});
        rows.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, '{1'b0, 13'd1, 1'b0}});
        rows.push_back('{-32'sd1, 32'sh0, 1'b0, none});
        rows.push_back('{32'sh0, -32'sd1, 1'b0, none});
        rows.push_back('{32'sh1000_0000, 32'sh0, 1'b0, none});
        rows.push_back('{-32'sh0800_0000, 32'sh0800_0000, 1'b0, none});
        rows.push_back('{32'sh0, 32'sh1000_0000, 1'b0, none});
        rows.push_back('{32'sh0199_999A, -32'sh0199_999A, 1'b0, none});
        rows.push_back('{32'sh1000_0000, 32'sh1000_0000, 1'b0, none});
        rows.push_back('{32'sh2000_0000, 32'sh0, 1'b0, none});
        rows.push_back('{32'sh0400_0000, 32'sh0C00_0000, 1'b0, none});
        rows.push_back('{-32'sh1800_0000, -32'sh0400_0000, 1'b0, none});

        plan.push_back('{32'sh1000_0000, 32'sh0, 4'd3, 12'd20, 70});
        plan.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000, 4'd8, 12'd12, 60});
        plan.push_back('{32'sh8000_0000, 32'sh7FFF_FFFF, 4'd4, 12'd16, 70});
        plan.push_back('{32'sh0, 32'sh0, 4'd0, 12'd10, 60});
        plan.push_back('{int'($urandom()), int'($urandom()), 4'd15, 12'd8, 60});
        plan.push_back('{int'($urandom()), int'($urandom()), 4'd5, 12'd0, 60});
        plan.push_back('{int'($urandom()), int'($urandom()), 4'd6, 12'd1, 60});
        plan.push_back('{32'sh0800_0000, 32'sh0400_0000, 4'd3, 12'd4095, 10});

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_point(rows[i].re, rows[i].im, rows[i].typed, rows[i].px);

        foreach (plan[p])
        begin
            apply_setting(plan[p]);
            quiet = (p == 2);
            for (int i = 0; i < plan[p].count; i++)
            begin
                // deep iteration limit only with far points so orbits leave quickly
                if (plan[p].iters == 12'd4095)
                    send_point(int'($urandom()) | 32'sh4000_0000, int'($urandom()), 1'b0, none);
                else
                    send_point(rand_point($urandom_range(1)), rand_point($urandom_range(1)),
                               1'b0, none);
            end
            quiet = 1'b0;
        end
        in_valid <= 1'b0;

        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("tb_critical_orbit_escape_time: done, clean");
        else
            $display("tb_critical_orbit_escape_time: done, errors");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("tb_critical_orbit_escape_time: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
